FILE: rtl/rsd_pkg.sv
// shared types and constants of the rs485 frame deframer
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd2;

    localparam logic [BYTE_W-1:0] OWN_ADDR_RST   = 8'h10;
    localparam logic [BYTE_W-1:0] BCAST_ADDR_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h16;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CHK  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] own_address;
        logic [BYTE_W-1:0] broadcast_address;
        logic [BYTE_W-1:0] start_byte;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              is_broadcast;
        logic              last;
        logic              frame_good;
    } result_t;

endpackage

FILE: rtl/rsd_ifs.sv
// valid/ready channel interfaces for received bytes and frame words
`timescale 1ns / 1ps

interface rsd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rsd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       is_broadcast;
    logic       last;
    logic       frame_good;

    modport source (output valid, output data_byte, output position,
                    output is_broadcast, output last, output frame_good,
                    input ready);
    modport sink   (input valid, input data_byte, input position,
                    input is_broadcast, input last, input frame_good,
                    output ready);
endinterface

FILE: rtl/rsd_cfg_regs.sv
// configuration registers: own address, broadcast address, start byte
`timescale 1ns / 1ps

module rsd_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsd_pkg::BYTE_W-1:0]    cfg_data,
    output rsd_pkg::cfg_t                 cfg
);
    import rsd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address       <= OWN_ADDR_RST;
            cfg_reg.broadcast_address <= BCAST_ADDR_RST;
            cfg_reg.start_byte        <= START_BYTE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDR:   cfg_reg.own_address       <= cfg_data;
                CFG_BCAST_ADDR: cfg_reg.broadcast_address <= cfg_data;
                CFG_START_BYTE: cfg_reg.start_byte        <= cfg_data;
                default:        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/rsd_in_reg.sv
// input byte register in front of the frame parser
`timescale 1ns / 1ps

module rsd_in_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    rsd_rx_if.sink                     rx,
    input  logic                       take,
    output logic                       byte_valid,
    output logic [rsd_pkg::BYTE_W-1:0] byte_data
);
    import rsd_pkg::*;

    logic              full_reg;
    logic              full_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    assign rx.ready = !full_reg || take;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        full_next = full_reg;
        if (accept)
            full_next = 1'b1;
        else if (take)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            data_reg <= rx.rx_byte;
    end

    assign byte_valid = full_reg;
    assign byte_data  = data_reg;

endmodule

FILE: rtl/rsd_parser.sv
// frame state tracking, address filter and checksum check
`timescale 1ns / 1ps

module rsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rsd_pkg::cfg_t              cfg,
    input  logic                       byte_valid,
    input  logic [rsd_pkg::BYTE_W-1:0] byte_data,
    input  logic                       out_free,
    output logic                       take,
    output logic                       res_load,
    output rsd_pkg::result_t           res
);
    import rsd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] remain_reg, remain_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [POS_W-1:0]  index_reg, index_next;
    logic              accepted_reg, accepted_next;
    logic              bcast_reg, bcast_next;
    logic              emit;
    logic              is_last;
    logic              good;

    always_comb
    begin
        phase_next    = phase_reg;
        remain_next   = remain_reg;
        sum_next      = sum_reg;
        index_next    = index_reg;
        accepted_next = accepted_reg;
        bcast_next    = bcast_reg;
        emit          = 1'b0;
        is_last       = 1'b0;
        good          = 1'b0;
        case (phase_reg)
            PH_ADDR:
            begin
                index_next    = POS_W'(1);
                sum_next      = byte_data;
                bcast_next    = (byte_data == cfg.broadcast_address);
                accepted_next = bcast_next || (byte_data == cfg.own_address);
                emit          = accepted_next;
                phase_next    = PH_CMD;
            end
            PH_CMD:
            begin
                index_next = POS_W'(2);
                sum_next   = sum_reg + byte_data;
                emit       = accepted_reg;
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                index_next  = POS_W'(3);
                sum_next    = sum_reg + byte_data;
                remain_next = byte_data;
                emit        = accepted_reg;
                phase_next  = (byte_data == '0) ? PH_CHK : PH_DATA;
            end
            PH_DATA:
            begin
                index_next  = index_reg + POS_W'(1);
                sum_next    = sum_reg + byte_data;
                remain_next = remain_reg - BYTE_W'(1);
                emit        = accepted_reg;
                if (remain_next == '0)
                    phase_next = PH_CHK;
            end
            PH_CHK:
            begin
                index_next = index_reg + POS_W'(1);
                emit       = accepted_reg;
                is_last    = 1'b1;
                good       = (sum_reg == byte_data);
                phase_next = PH_HUNT;
            end
            default:
            begin
                // hunting, unused codes included
                phase_next = PH_HUNT;
                if (byte_data == cfg.start_byte)
                begin
                    index_next    = '0;
                    sum_next      = '0;
                    remain_next   = '0;
                    accepted_next = 1'b0;
                    bcast_next    = 1'b0;
                    phase_next    = PH_ADDR;
                end
            end
        endcase
    end

    assign take     = byte_valid && (!emit || out_free);
    assign res_load = byte_valid && emit && out_free;

    assign res.data_byte    = byte_data;
    assign res.position     = index_next;
    assign res.is_broadcast = bcast_next;
    assign res.last         = is_last;
    assign res.frame_good   = good;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            remain_reg   <= '0;
            sum_reg      <= '0;
            index_reg    <= '0;
            accepted_reg <= 1'b0;
            bcast_reg    <= 1'b0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            remain_reg   <= remain_next;
            sum_reg      <= sum_next;
            index_reg    <= index_next;
            accepted_reg <= accepted_next;
            bcast_reg    <= bcast_next;
        end
    end

`ifndef SYNTHESIS
    a_data_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> remain_reg != '0)
        else $error("data phase with no data bytes left");

    a_hunt_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_CHK |=> phase_reg == PH_HUNT)
        else $error("no return to hunting after checksum byte");

    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && res.last |-> res.position >= POS_W'(4) && res.position <= POS_W'(259))
        else $error("checksum word at impossible position");

    a_no_emit_hunting: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> !res_load)
        else $error("word emitted while hunting");
`endif

endmodule

FILE: rtl/rsd_out_reg.sv
// result word register toward the sink
`timescale 1ns / 1ps

module rsd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rsd_pkg::result_t res_in,
    output logic             out_free,
    rsd_res_if.source        res
);
    import rsd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign out_free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= res_in;
    end

    assign res.valid        = valid_reg;
    assign res.data_byte    = word_reg.data_byte;
    assign res.position     = word_reg.position;
    assign res.is_broadcast = word_reg.is_broadcast;
    assign res.last         = word_reg.last;
    assign res.frame_good   = word_reg.frame_good;

endmodule

FILE: rtl/rs485_frame_deframer.sv
// top level of the rs485 frame deframer
//
//   channel  dir  payload                                          handshake
//   rx       in   rx_byte                                          valid/ready
//   res      out  data_byte position is_broadcast last frame_good  valid/ready
//   cfg      in   cfg_index cfg_data                               cfg_we
//
// one byte per cycle unless a word-producing byte meets a stalled result
// register; a byte passes input register, parser, result register in order
// a stalled result register holds only bytes that produce a word
// asynchronous active-low reset returns to hunting, registers to defaults
`timescale 1ns / 1ps

module rs485_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsd_pkg::BYTE_W-1:0]    cfg_data,
    rsd_rx_if.sink                        rx,
    rsd_res_if.source                     res
);
    import rsd_pkg::*;

    cfg_t              cfg;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              take;
    logic              res_load;
    logic              out_free;
    result_t           word;

    rsd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsd_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    rsd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .take       (take),
        .res_load   (res_load),
        .res        (word)
    );

    rsd_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_load),
        .res_in   (word),
        .out_free (out_free),
        .res      (res)
    );

endmodule
